// ===== src/ucc_pkg.sv =====
// ----------------------------------------------------------------------------
// ucc_pkg
// Shared types, constants and calendar helper functions for the converter.
// ----------------------------------------------------------------------------
package ucc_pkg;

   // request commands
   typedef enum logic {
      CMD_SPLIT = 1'b0,
      CMD_BUILD = 1'b1
   } cmd_type;

   localparam logic [31:0] EPOCH_YEAR    = 32'd1970;
   localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
   // reciprocal for division by 25 and 100 on 32-bit values
   localparam logic [63:0] RECIP_25_100  = 64'h51EB851F;
   // reciprocal for division by 86400 (shift 48)
   localparam logic [63:0] RECIP_86400   = 64'hC22E4507;

   typedef logic [8:0] dtm_type;

   // cumulative days before each month, non-leap
   localparam dtm_type DAYS_BEFORE [12] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   // gregorian leap rule on a 12-bit year
   function automatic logic leap_year(input logic [11:0] y);
      logic [24:0] p;
      logic [5:0]  q;
      logic        div100;
      p      = {13'b0, y} * 25'd5243;
      q      = p[24:19];
      div100 = (12'({q, 2'b00} * 12'd25) == y);
      return ((y[1:0] == 2'b00) && !div100) || (div100 && (y[3:0] == 4'd0));
   endfunction

   // days before the given month, month clamped to 1..12
   function automatic dtm_type month_start_days(input logic [11:0] y, input logic [3:0] m);
      logic [3:0] mc;
      dtm_type    d;
      mc = m;
      if (mc < 4'd1) mc = 4'd1;
      if (mc > 4'd12) mc = 4'd12;
      d = DAYS_BEFORE[mc - 4'd1];
      if ((mc > 4'd2) && leap_year(y)) d = d + 9'd1;
      return d;
   endfunction

   // days from 1970 to the start of year 1970 + k, k small
   function automatic logic [16:0] days_to_year_small(input logic [7:0] k);
      logic [16:0] d;
      logic [8:0]  t100;
      logic [9:0]  t400;
      t100 = {1'b0, k} + 9'd69;
      t400 = {2'b0, k} + 10'd369;
      d = 17'({9'b0, k} * 17'd365) + 17'(({1'b0, k} + 9'd1) >> 2);
      if (t100 >= 9'd200) d = d - 17'd2;
      else if (t100 >= 9'd100) d = d - 17'd1;
      if (t400 >= 10'd400) d = d + 17'd1;
      return d;
   endfunction

endpackage

// ===== src/ucc_build.sv =====
// ----------------------------------------------------------------------------
// ucc_build
// Three-stage front end: forms the seconds count from calendar fields, or
// passes the given seconds, wrapping modulo 2^32.
// ----------------------------------------------------------------------------
module ucc_build import ucc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic        command,
   input  logic [31:0] seconds_in,
   input  logic [11:0] year_in,
   input  logic [3:0]  month_in,
   input  logic [4:0]  day_in,
   input  logic [4:0]  hour_in,
   input  logic [5:0]  minute_in,
   input  logic [5:0]  second_in,
   output logic        out_valid,
   output logic [31:0] out_seconds
);

   logic        v1_ff, v2_ff, v3_ff;
   logic        cmd1_ff, cmd2_ff;
   logic [31:0] secs1_ff, secs2_ff, secs3_ff, secs3_in;
   logic [31:0] p365_ff, p365_in, quart_ff, quart_in;
   logic [63:0] q100_ff, q100_in, q400_ff, q400_in;
   dtm_type     dtm_ff, dtm_in;
   logic [4:0]  day_ff;
   logic [10:0] hm_ff, hm_in;
   logic [5:0]  sec_ff;
   logic [31:0] days2_ff, days2_in;
   logic [16:0] tsec2_ff, tsec2_in;
   logic [31:0] k, x100, x400;

   // stage 1: year terms and month offset
   always_comb begin
      k        = {20'b0, year_in} - EPOCH_YEAR;
      x100     = k + 32'd69;
      x400     = k + 32'd369;
      p365_in  = k * 32'd365;
      quart_in = (k + 32'd1) >> 2;
      q100_in  = {32'b0, x100} * RECIP_25_100;
      q400_in  = {36'b0, x400[31:4]} * RECIP_25_100;
      dtm_in   = month_start_days(year_in, month_in);
      hm_in    = 11'({6'b0, hour_in} * 11'd60) + {5'b0, minute_in};
   end

   // stage 2: day count and time of day
   always_comb begin
      days2_in = p365_ff + quart_ff - {5'b0, q100_ff[63:37]} + {3'b0, q400_ff[63:35]}
               + {23'b0, dtm_ff} + {27'b0, day_ff} - 32'd1;
      tsec2_in = 17'({6'b0, hm_ff} * 17'd60) + {11'b0, sec_ff};
   end

   // stage 3: seconds select
   always_comb begin
      if (cmd2_ff == CMD_BUILD) begin
         secs3_in = days2_ff * SECS_PER_DAY + {15'b0, tsec2_ff};
      end else begin
         secs3_in = secs2_ff;
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         cmd1_ff  <= command;
         secs1_ff <= seconds_in;
         p365_ff  <= p365_in;
         quart_ff <= quart_in;
         q100_ff  <= q100_in;
         q400_ff  <= q400_in;
         dtm_ff   <= dtm_in;
         day_ff   <= day_in;
         hm_ff    <= hm_in;
         sec_ff   <= second_in;
         cmd2_ff  <= cmd1_ff;
         secs2_ff <= secs1_ff;
         days2_ff <= days2_in;
         tsec2_ff <= tsec2_in;
         secs3_ff <= secs3_in;
      end
   end

   assign out_valid   = v3_ff;
   assign out_seconds = secs3_ff;

endmodule

// ===== src/ucc_split.sv =====
// ----------------------------------------------------------------------------
// ucc_split
// Five-stage back end: splits a seconds count into date, time and weekday
// using reciprocal multiplies and one-step year and month corrections.
// ----------------------------------------------------------------------------
module ucc_split import ucc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [31:0] in_seconds,
   output logic        out_valid,
   output logic [31:0] seconds_out,
   output logic [11:0] year_out,
   output logic [3:0]  month_out,
   output logic [4:0]  day_out,
   output logic [4:0]  hour_out,
   output logic [5:0]  minute_out,
   output logic [5:0]  second_out,
   output logic [2:0]  weekday_out
);

   logic        v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [31:0] secs1_ff, secs2_ff, secs3_ff, secs4_ff, secs5_ff;
   logic [63:0] pday_ff, pday_in;
   logic [15:0] days2_ff;
   logic [16:0] tod2_ff, tod2_in, tod3_ff;
   logic [31:0] yq2_ff, yq2_in, tmp_tod;
   logic [4:0]  hour3_ff, hour3_in, hour4_ff, hour5_ff;
   logic [10:0] mt3_ff, mt3_in;
   logic [15:0] d33_ff, d3;
   logic [12:0] wq3_ff, wq3_in;
   logic [11:0] year3_ff, year3_in, year4_ff;
   logic [8:0]  doy3_ff, doy3_in, doy4_ff;
   logic [5:0]  min4_ff, min4_in, min5_ff, sec4_ff, sec4_in, sec5_ff;
   logic [2:0]  wd4_ff, wd4_in, wd5_ff;
   logic [3:0]  mest4_ff, mest4_in;
   logic [11:0] year5_ff;
   logic [3:0]  mon5_ff, mon5_in;
   logic [4:0]  day5_ff, day5_in;
   logic [33:0] ph;
   logic [34:0] pm;
   logic [31:0] pw;
   logic [7:0]  k;
   logic [16:0] dty0, dty1, dty, doy_w;
   logic        early;
   logic [10:0] tmp_min;
   logic [16:0] tmp_sec;
   logic [15:0] tmp_wd;
   logic [17:0] pmon;
   logic [3:0]  mc;
   dtm_type     dtm_a, dtm_f;
   logic [8:0]  tmp_day;

   // stage 1: day quotient product
   assign pday_in = {32'b0, in_seconds} * RECIP_86400;

   // stage 2: day count, time of day, year estimate product
   always_comb begin
      tmp_tod = secs1_ff - {16'b0, pday_ff[63:48]} * SECS_PER_DAY;
      tod2_in = tmp_tod[16:0];
      yq2_in  = {16'b0, pday_ff[63:48]} * 32'd45965;
   end

   // stage 3: hour, minute and weekday quotients, year correction
   always_comb begin
      ph       = {17'b0, tod2_ff} * 34'd37283;
      pm       = {18'b0, tod2_ff} * 35'd139811;
      d3       = days2_ff + 16'd3;
      pw       = {16'b0, d3} * 32'd74899;
      hour3_in = ph[31:27];
      mt3_in   = pm[33:23];
      wq3_in   = pw[31:19];
      k        = yq2_ff[31:24];
      dty0     = days_to_year_small(k);
      dty1     = days_to_year_small(k - 8'd1);
      early    = {1'b0, days2_ff} < dty0;
      dty      = early ? dty1 : dty0;
      year3_in = 12'd1970 + {4'b0, k} - {11'b0, early};
      doy_w    = {1'b0, days2_ff} - dty + 17'd1;
      doy3_in  = doy_w[8:0];
   end

   // stage 4: remainders and month estimate
   always_comb begin
      tmp_min  = mt3_ff - 11'({6'b0, hour3_ff} * 11'd60);
      min4_in  = tmp_min[5:0];
      tmp_sec  = tod3_ff - 17'({6'b0, mt3_ff} * 17'd60);
      sec4_in  = tmp_sec[5:0];
      tmp_wd   = d33_ff - 16'({3'b0, wq3_ff} * 16'd7);
      wd4_in   = tmp_wd[2:0];
      pmon     = {9'b0, doy3_ff} * 18'd565;
      mest4_in = pmon[17:14] + 4'd1;
   end

   // stage 5: month correction and day of month
   always_comb begin
      mc    = (mest4_ff > 4'd12) ? 4'd12 : mest4_ff;
      dtm_a = month_start_days(year4_ff, mc);
      if ((doy4_ff <= dtm_a) && (mc > 4'd1)) begin
         mon5_in = mc - 4'd1;
      end else begin
         mon5_in = mc;
      end
      dtm_f   = month_start_days(year4_ff, mon5_in);
      tmp_day = doy4_ff - dtm_f;
      day5_in = tmp_day[4:0];
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         secs1_ff <= in_seconds;
         pday_ff  <= pday_in;
         secs2_ff <= secs1_ff;
         days2_ff <= pday_ff[63:48];
         tod2_ff  <= tod2_in;
         yq2_ff   <= yq2_in;
         secs3_ff <= secs2_ff;
         tod3_ff  <= tod2_ff;
         hour3_ff <= hour3_in;
         mt3_ff   <= mt3_in;
         d33_ff   <= d3;
         wq3_ff   <= wq3_in;
         year3_ff <= year3_in;
         doy3_ff  <= doy3_in;
         secs4_ff <= secs3_ff;
         hour4_ff <= hour3_ff;
         min4_ff  <= min4_in;
         sec4_ff  <= sec4_in;
         wd4_ff   <= wd4_in;
         mest4_ff <= mest4_in;
         year4_ff <= year3_ff;
         doy4_ff  <= doy3_ff;
         secs5_ff <= secs4_ff;
         year5_ff <= year4_ff;
         mon5_ff  <= mon5_in;
         day5_ff  <= day5_in;
         hour5_ff <= hour4_ff;
         min5_ff  <= min4_ff;
         sec5_ff  <= sec4_ff;
         wd5_ff   <= wd4_ff;
      end
   end

   assign out_valid   = v5_ff;
   assign seconds_out = secs5_ff;
   assign year_out    = year5_ff;
   assign month_out   = mon5_ff;
   assign day_out     = day5_ff;
   assign hour_out    = hour5_ff;
   assign minute_out  = min5_ff;
   assign second_out  = sec5_ff;
   assign weekday_out = wd5_ff;

endmodule

// ===== src/unix_seconds_calendar_convert_unit.sv =====
// ----------------------------------------------------------------------------
// unix_seconds_calendar_convert_unit
// Converts between unix seconds and calendar date, time and weekday.
// ----------------------------------------------------------------------------
// pipeline: 3 build stages then 5 split stages from request accept to response valid
// throughput: one request per cycle; the whole pipeline holds while the
// output register is full and stalled
// reset: synchronous, clears all stage valid bits; no other state
module unix_seconds_calendar_convert_unit import ucc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [31:0] req_seconds_in,
   input  logic [11:0] req_year_in,
   input  logic [3:0]  req_month_in,
   input  logic [4:0]  req_day_in,
   input  logic [4:0]  req_hour_in,
   input  logic [5:0]  req_minute_in,
   input  logic [5:0]  req_second_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_seconds_out,
   output logic [11:0] rsp_year_out,
   output logic [3:0]  rsp_month_out,
   output logic [4:0]  rsp_day_out,
   output logic [4:0]  rsp_hour_out,
   output logic [5:0]  rsp_minute_out,
   output logic [5:0]  rsp_second_out,
   output logic [2:0]  rsp_weekday_out
);

   logic        en;
   logic        mid_valid;
   logic [31:0] mid_seconds;

   // pipeline advances unless the output holds a stalled response
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   ucc_build u_build (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_valid),
      .command     (req_command),
      .seconds_in  (req_seconds_in),
      .year_in     (req_year_in),
      .month_in    (req_month_in),
      .day_in      (req_day_in),
      .hour_in     (req_hour_in),
      .minute_in   (req_minute_in),
      .second_in   (req_second_in),
      .out_valid   (mid_valid),
      .out_seconds (mid_seconds)
   );

   ucc_split u_split (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (mid_valid),
      .in_seconds  (mid_seconds),
      .out_valid   (rsp_valid),
      .seconds_out (rsp_seconds_out),
      .year_out    (rsp_year_out),
      .month_out   (rsp_month_out),
      .day_out     (rsp_day_out),
      .hour_out    (rsp_hour_out),
      .minute_out  (rsp_minute_out),
      .second_out  (rsp_second_out),
      .weekday_out (rsp_weekday_out)
   );

endmodule

// ===== src/ucc_checker.sv =====
// ----------------------------------------------------------------------------
// ucc_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module ucc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_seconds_out,
   input logic [3:0]  rsp_month_out,
   input logic [5:0]  rsp_second_out,
   input logic [2:0]  rsp_weekday_out
);

   // stalled response holds its seconds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_seconds_out))
      else $error("stalled response changed");

   // request side stalls only behind a stalled response
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without output back pressure");

   // month in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_month_out >= 4'd1 && rsp_month_out <= 4'd12)
      else $error("month out of range");

   // second and weekday in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_second_out < 6'd60 && rsp_weekday_out < 3'd7)
      else $error("second or weekday out of range");

endmodule

bind unix_seconds_calendar_convert_unit ucc_checker u_ucc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_seconds_out (rsp_seconds_out),
   .rsp_month_out   (rsp_month_out),
   .rsp_second_out  (rsp_second_out),
   .rsp_weekday_out (rsp_weekday_out)
);
